// ===== rtl/rgs_pkg.sv =====
// Shared types, constants and a helper function for the rotated grid snap block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rgs_pkg;

  localparam int COORD_W  = 32;
  localparam int QUAT_FB  = 14;
  localparam int QUAT_W   = QUAT_FB + 2;
  localparam int MCOEF_W  = QUAT_FB + 3;
  localparam int SNAP_W   = 24;

  // Pipeline depths of the sub-units and the stage at which each value appears.
  localparam int ROT_LAT  = 2;
  localparam int MV_LAT   = 2;
  localparam int DIV_BITS = COORD_W + 1;
  localparam int SNAP_LAT = DIV_BITS + 3;
  localparam int M_T      = ROT_LAT;
  localparam int U_T      = M_T + MV_LAT;
  localparam int S_T      = U_T + SNAP_LAT;
  localparam int R_T      = S_T + MV_LAT;
  localparam int OUT_LAT  = R_T + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [MCOEF_W-1:0] mcoef_t;
  typedef logic [SNAP_W-1:0]         snap_t;
  typedef coord_t [2:0]              vec3_t;
  typedef mcoef_t [2:0][2:0]         mat3_t;

  typedef struct packed {
    coord_t ref_x;
    coord_t ref_y;
    coord_t ref_z;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    quat_t  rot_w;
    quat_t  rot_x;
    quat_t  rot_y;
    quat_t  rot_z;
  } req_t;

  typedef struct packed {
    coord_t placed_x;
    coord_t placed_y;
    coord_t placed_z;
    coord_t offset_x;
    coord_t offset_y;
    coord_t offset_z;
  } rsp_t;

  function automatic coord_t sat_coord(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd1 <<< (COORD_W - 1);
    lo = -hi;
    hi = hi - 64'sd1;
    if (v > hi) begin
      return coord_t'(hi);
    end else if (v < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgs_rot_mat.sv =====
// Builds the 3x3 rotation matrix from a Q1.14 quaternion in two register stages.
// Depends on rgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgs_rot_mat (
  input  wire logic           clk_i,
  input  rgs_pkg::quat_t      w_i,
  input  rgs_pkg::quat_t      x_i,
  input  rgs_pkg::quat_t      y_i,
  input  rgs_pkg::quat_t      z_i,
  output rgs_pkg::mat3_t      mat_o
);

  localparam int PW = 2 * rgs_pkg::QUAT_W;
  localparam int DW = PW - rgs_pkg::QUAT_FB + 2;
  localparam int EW = DW + 2;

  // Products in order xx, yy, zz, xy, xz, yz, wx, wy, wz.
  logic signed [PW-1:0] prod_q [9];
  rgs_pkg::mat3_t       mat_q;

  function automatic logic signed [DW-1:0] dbl(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t = (PW+1)'(p) + ((PW+1)'(1) <<< (rgs_pkg::QUAT_FB - 2));
    return t[PW:rgs_pkg::QUAT_FB-1];
  endfunction

  function automatic rgs_pkg::mcoef_t clampm(input logic signed [EW-1:0] e);
    logic signed [EW-1:0] lim;
    lim = EW'(1) <<< (rgs_pkg::QUAT_FB + 1);
    if (e > lim) begin
      return rgs_pkg::mcoef_t'(lim);
    end else if (e < -lim) begin
      return rgs_pkg::mcoef_t'(-lim);
    end
    return rgs_pkg::mcoef_t'(e);
  endfunction

  always_ff @(posedge clk_i) begin
    prod_q[0] <= PW'(x_i * x_i);
    prod_q[1] <= PW'(y_i * y_i);
    prod_q[2] <= PW'(z_i * z_i);
    prod_q[3] <= PW'(x_i * y_i);
    prod_q[4] <= PW'(x_i * z_i);
    prod_q[5] <= PW'(y_i * z_i);
    prod_q[6] <= PW'(w_i * x_i);
    prod_q[7] <= PW'(w_i * y_i);
    prod_q[8] <= PW'(w_i * z_i);
  end

  always_ff @(posedge clk_i) begin
    logic signed [EW-1:0] one;
    logic signed [EW-1:0] d [9];
    one = EW'(1) <<< rgs_pkg::QUAT_FB;
    for (int k = 0; k < 9; k++) begin
      d[k] = EW'(dbl(prod_q[k]));
    end
    mat_q[0][0] <= clampm(one - d[1] - d[2]);
    mat_q[0][1] <= clampm(d[3] - d[8]);
    mat_q[0][2] <= clampm(d[4] + d[7]);
    mat_q[1][0] <= clampm(d[3] + d[8]);
    mat_q[1][1] <= clampm(one - d[0] - d[2]);
    mat_q[1][2] <= clampm(d[5] - d[6]);
    mat_q[2][0] <= clampm(d[4] - d[7]);
    mat_q[2][1] <= clampm(d[5] + d[6]);
    mat_q[2][2] <= clampm(one - d[0] - d[1]);
  end

  assign mat_o = mat_q;

endmodule

`default_nettype wire

// ===== rtl/rgs_mat_vec.sv =====
// Matrix times vector with Q.14 coefficients, rounded half up and saturated.
// Two register stages: products, then sum and round. Depends on rgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgs_mat_vec (
  input  wire logic        clk_i,
  input  rgs_pkg::mat3_t   mat_i,
  input  rgs_pkg::vec3_t   vec_i,
  output rgs_pkg::vec3_t   vec_o
);

  localparam int PW = rgs_pkg::MCOEF_W + rgs_pkg::COORD_W;
  localparam int AW = PW + 2;
  localparam int RW = AW - rgs_pkg::QUAT_FB;

  logic signed [PW-1:0] prod_q [3][3];
  rgs_pkg::vec3_t       res_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= PW'($signed(mat_i[i][j]) * $signed(vec_i[j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [AW-1:0] acc;
    logic signed [RW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      acc = AW'(prod_q[i][0]) + AW'(prod_q[i][1]) + AW'(prod_q[i][2])
          + (AW'(1) <<< (rgs_pkg::QUAT_FB - 1));
      sh = acc[AW-1:rgs_pkg::QUAT_FB];
      res_q[i] <= rgs_pkg::sat_coord(64'(sh));
    end
  end

  assign vec_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/rgs_snap.sv =====
// Snaps one coordinate to the nearest multiple of the grid size, halves up.
// A restoring divider pipeline, one quotient bit per stage. Depends on rgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgs_snap (
  input  wire logic        clk_i,
  input  rgs_pkg::coord_t  c_i,
  input  rgs_pkg::snap_t   size_i,
  output rgs_pkg::coord_t  s_o
);

  localparam int NB = rgs_pkg::DIV_BITS;
  localparam int DW = rgs_pkg::SNAP_W + 1;
  localparam int MW = NB + 1 + DW;

  logic [NB-1:0]       num_q [NB+1];
  logic [DW-1:0]       rem_q [NB+1];
  logic [NB-1:0]       quo_q [NB+1];
  logic                neg_q [NB+1];
  rgs_pkg::coord_t     c_q   [NB+1];
  logic [DW-1:0]       rem_d [NB+1];
  logic                ge_d  [NB+1];
  logic [DW-1:0]       den;
  logic signed [NB:0]  n2;
  logic signed [MW-1:0] prod_q;
  rgs_pkg::coord_t     c_m_q;
  rgs_pkg::coord_t     s_q;

  assign den = {size_i, 1'b0};
  // Numerator 2c + g; the divide floors (2c + g) / 2g.
  assign n2  = $signed({c_i[rgs_pkg::COORD_W-1], c_i, 1'b0}) + $signed({2'b00, size_i});

  always_comb begin
    logic [DW:0] t;
    rem_d[0] = '0;
    ge_d[0]  = 1'b0;
    for (int k = 1; k <= NB; k++) begin
      t = {rem_q[k-1], num_q[k-1][NB-1]};
      ge_d[k]  = (t >= {1'b0, den});
      rem_d[k] = ge_d[k] ? DW'(t - {1'b0, den}) : t[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    // A negative numerator divides its complement, and the quotient is complemented back.
    num_q[0] <= n2[NB] ? ~n2[NB-1:0] : n2[NB-1:0];
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    neg_q[0] <= n2[NB];
    c_q[0]   <= c_i;
    for (int k = 1; k <= NB; k++) begin
      num_q[k] <= num_q[k-1] << 1;
      rem_q[k] <= rem_d[k];
      quo_q[k] <= {quo_q[k-1][NB-2:0], ge_d[k]};
      neg_q[k] <= neg_q[k-1];
      c_q[k]   <= c_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= MW'($signed({1'b0, quo_q[NB]} ^ {(NB+1){neg_q[NB]}})
                * $signed({1'b0, size_i}));
    c_m_q  <= c_q[NB];
    s_q    <= (size_i == '0) ? c_m_q : rgs_pkg::sat_coord(64'(prod_q));
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

// ===== rtl/rotated_grid_snap.sv =====
// Rotated grid snap: takes one placement query per clock and never asserts busy.
// Each query accepted with start is answered by a one-cycle done_o beat.
// The receiver cannot stall, so it must take every beat. The depth is set by the snap
// divider, 36 stages: an input register, one quotient bit per stage over 33 bits, the
// rounding product and the output register; and by the rotation around it: two stages
// for the matrix, two for each of the two matrix passes and one for the final sums.
// Write snap_size only with no query in flight.
// Depends on rgs_pkg, rgs_rot_mat, rgs_mat_vec and rgs_snap.
`timescale 1ns / 1ps
`default_nettype none

module rotated_grid_snap (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  rgs_pkg::req_t        req_i,
  output logic                 done_o,
  output rgs_pkg::rsp_t        rsp_o,
  input  wire logic            cfg_we_i,
  input  rgs_pkg::snap_t       cfg_wdata_i
);

  localparam int RT = rgs_pkg::R_T;
  localparam int MD = rgs_pkg::S_T - rgs_pkg::M_T;
  localparam int UD = rgs_pkg::R_T - rgs_pkg::U_T;
  localparam int SD = rgs_pkg::MV_LAT;

  rgs_pkg::snap_t  snap_q;
  logic [RT-1:0]   vld_q;
  rgs_pkg::vec3_t  d1_q, d2_q;
  rgs_pkg::vec3_t  org_in;
  rgs_pkg::vec3_t  org_dly_q [RT];
  rgs_pkg::mat3_t  m_dly_q [MD];
  rgs_pkg::vec3_t  u_dly_q [UD];
  rgs_pkg::vec3_t  s_dly_q [SD];
  rgs_pkg::mat3_t  mat, mat_t;
  rgs_pkg::vec3_t  u, s, r;
  rgs_pkg::rsp_t   rsp_q;
  logic            done_q;

  assign busy   = 1'b0;
  assign org_in = {req_i.origin_z, req_i.origin_y, req_i.origin_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= '0;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        snap_q <= cfg_wdata_i;
      end
      vld_q  <= {vld_q[RT-2:0], start & ~busy};
      done_q <= vld_q[RT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q[0] <= rgs_pkg::sat_coord(64'(req_i.ref_x) - 64'(req_i.origin_x));
    d1_q[1] <= rgs_pkg::sat_coord(64'(req_i.ref_y) - 64'(req_i.origin_y));
    d1_q[2] <= rgs_pkg::sat_coord(64'(req_i.ref_z) - 64'(req_i.origin_z));
    d2_q    <= d1_q;
    org_dly_q[0] <= org_in;
    for (int k = 1; k < RT; k++) begin
      org_dly_q[k] <= org_dly_q[k-1];
    end
    m_dly_q[0] <= mat;
    for (int k = 1; k < MD; k++) begin
      m_dly_q[k] <= m_dly_q[k-1];
    end
    u_dly_q[0] <= u;
    for (int k = 1; k < UD; k++) begin
      u_dly_q[k] <= u_dly_q[k-1];
    end
    s_dly_q[0] <= s;
    for (int k = 1; k < SD; k++) begin
      s_dly_q[k] <= s_dly_q[k-1];
    end
  end

  rgs_rot_mat u_rot (
    .clk_i (clk_i),
    .w_i   (req_i.rot_w),
    .x_i   (req_i.rot_x),
    .y_i   (req_i.rot_y),
    .z_i   (req_i.rot_z),
    .mat_o (mat)
  );

  // The inverse rotation of a unit quaternion is the transposed matrix.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_t[i][j] = mat[j][i];
      end
    end
  end

  rgs_mat_vec u_to_grid (
    .clk_i (clk_i),
    .mat_i (mat_t),
    .vec_i (d2_q),
    .vec_o (u)
  );

  assign s[0] = u_dly_q[rgs_pkg::SNAP_LAT-1][0];

  rgs_snap u_snap_y (
    .clk_i  (clk_i),
    .c_i    (u[1]),
    .size_i (snap_q),
    .s_o    (s[1])
  );

  rgs_snap u_snap_z (
    .clk_i  (clk_i),
    .c_i    (u[2]),
    .size_i (snap_q),
    .s_o    (s[2])
  );

  rgs_mat_vec u_to_world (
    .clk_i (clk_i),
    .mat_i (m_dly_q[MD-1]),
    .vec_i (s),
    .vec_o (r)
  );

  always_ff @(posedge clk_i) begin
    rsp_q.placed_x <= rgs_pkg::sat_coord(64'(r[0]) + 64'(org_dly_q[RT-1][0]));
    rsp_q.placed_y <= rgs_pkg::sat_coord(64'(r[1]) + 64'(org_dly_q[RT-1][1]));
    rsp_q.placed_z <= rgs_pkg::sat_coord(64'(r[2]) + 64'(org_dly_q[RT-1][2]));
    rsp_q.offset_x <= '0;
    rsp_q.offset_y <= rgs_pkg::sat_coord(64'(u_dly_q[UD-1][1]) - 64'(s_dly_q[SD-1][1]));
    rsp_q.offset_z <= rgs_pkg::sat_coord(64'(u_dly_q[UD-1][2]) - 64'(s_dly_q[SD-1][2]));
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Every accepted query produces its result beat after the full pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rgs_pkg::OUT_LAT) done_o)
    else $error("accepted query did not complete after the pipeline depth");

  // A rising result beat never appears without a query accepted at the matching cycle.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(start && !busy, rgs_pkg::OUT_LAT))
    else $error("result beat without a matching accepted query");

  a_offset_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.offset_x == '0))
    else $error("X offset must be zero");

endmodule

`default_nettype wire

// ===== sim/tb_rotated_grid_snap.sv =====
// Self-checking testbench for rotated_grid_snap: directed and random placement queries,
// each predicted in the testbench and compared beat by beat with the block's results.
// Depends on rgs_pkg and rotated_grid_snap from rtl/.
`timescale 1ns / 1ps

module tb_rotated_grid_snap;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint MLIM = 64'sd1 <<< (rgs_pkg::QUAT_FB + 1);
  localparam int WATCHDOG_LIMIT = 5000;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  rgs_pkg::req_t  req_i;
  logic           done_o;
  rgs_pkg::rsp_t  rsp_o;
  logic           cfg_we_i;
  rgs_pkg::snap_t cfg_wdata_i;

  rgs_pkg::snap_t grid_spacing;
  rgs_pkg::rsp_t  placement_q[$];
  int             mismatches;
  int             stall_cycles;

  rotated_grid_snap DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint sat_coord_l(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic longint clamp_coef(longint v);
    return v > MLIM ? MLIM : (v < -MLIM ? -MLIM : v);
  endfunction

  // Doubled product 2ab brought to Q.F with halves rounding up.
  function automatic longint dbl_prod(longint a, longint b);
    return (a * b + (64'sd1 <<< (rgs_pkg::QUAT_FB - 2))) >>> (rgs_pkg::QUAT_FB - 1);
  endfunction

  function automatic longint row_dot(input longint m[3], input longint v[3]);
    longint acc_hi;
    longint acc_lo;
    acc_hi = 0;
    acc_lo = 0;
    for (int j = 0; j < 3; j++) begin
      acc_hi += (v[j] >>> rgs_pkg::QUAT_FB) * m[j];
      acc_lo += (v[j] & ((64'sd1 <<< rgs_pkg::QUAT_FB) - 1)) * m[j];
    end
    acc_lo = (acc_lo + (64'sd1 <<< (rgs_pkg::QUAT_FB - 1))) >>> rgs_pkg::QUAT_FB;
    return sat_coord_l(acc_hi + acc_lo);
  endfunction

  function automatic longint snap_coord(longint c);
    longint g;
    longint n;
    longint q;
    g = longint'(grid_spacing);
    if (g == 0) return c;
    n = 2 * c + g;
    q = n / (2 * g);
    if (n % (2 * g) != 0 && n < 0) q--;
    return sat_coord_l(q * g);
  endfunction

  function automatic rgs_pkg::rsp_t predict_placement(rgs_pkg::req_t r);
    longint org[3], d[3], u[3], s[3], rb[3];
    longint w, x, y, z, one;
    longint m[3][3];
    longint row[3];
    rgs_pkg::rsp_t p;
    one = 64'sd1 <<< rgs_pkg::QUAT_FB;
    org = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
    d[0] = sat_coord_l(longint'(r.ref_x) - org[0]);
    d[1] = sat_coord_l(longint'(r.ref_y) - org[1]);
    d[2] = sat_coord_l(longint'(r.ref_z) - org[2]);
    w = r.rot_w;
    x = r.rot_x;
    y = r.rot_y;
    z = r.rot_z;
    m[0][0] = one - dbl_prod(y, y) - dbl_prod(z, z);
    m[0][1] = dbl_prod(x, y) - dbl_prod(w, z);
    m[0][2] = dbl_prod(x, z) + dbl_prod(w, y);
    m[1][0] = dbl_prod(x, y) + dbl_prod(w, z);
    m[1][1] = one - dbl_prod(x, x) - dbl_prod(z, z);
    m[1][2] = dbl_prod(y, z) - dbl_prod(w, x);
    m[2][0] = dbl_prod(x, z) - dbl_prod(w, y);
    m[2][1] = dbl_prod(y, z) + dbl_prod(w, x);
    m[2][2] = one - dbl_prod(x, x) - dbl_prod(y, y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = clamp_coef(m[i][j]);
    // Into the grid frame with the transposed matrix.
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[j] = m[j][i];
      u[i] = row_dot(row, d);
    end
    s[0] = u[0];
    s[1] = snap_coord(u[1]);
    s[2] = snap_coord(u[2]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[j] = m[i][j];
      rb[i] = row_dot(row, s);
    end
    p.placed_x = rgs_pkg::coord_t'(sat_coord_l(rb[0] + org[0]));
    p.placed_y = rgs_pkg::coord_t'(sat_coord_l(rb[1] + org[1]));
    p.placed_z = rgs_pkg::coord_t'(sat_coord_l(rb[2] + org[2]));
    p.offset_x = '0;
    p.offset_y = rgs_pkg::coord_t'(sat_coord_l(u[1] - s[1]));
    p.offset_z = rgs_pkg::coord_t'(sat_coord_l(u[2] - s[2]));
    return p;
  endfunction

  task automatic report_mismatch(string field, rgs_pkg::coord_t got, rgs_pkg::coord_t want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // Result checker: every done_o beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    rgs_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (placement_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        mismatches++;
      end else begin
        want = placement_q.pop_front();
        if (rsp_o.placed_x !== want.placed_x)
          report_mismatch("placed_x", rsp_o.placed_x, want.placed_x);
        if (rsp_o.placed_y !== want.placed_y)
          report_mismatch("placed_y", rsp_o.placed_y, want.placed_y);
        if (rsp_o.placed_z !== want.placed_z)
          report_mismatch("placed_z", rsp_o.placed_z, want.placed_z);
        if (rsp_o.offset_x !== want.offset_x)
          report_mismatch("offset_x", rsp_o.offset_x, want.offset_x);
        if (rsp_o.offset_y !== want.offset_y)
          report_mismatch("offset_y", rsp_o.offset_y, want.offset_y);
        if (rsp_o.offset_z !== want.offset_z)
          report_mismatch("offset_z", rsp_o.offset_z, want.offset_z);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles = 0;
    end else if (++stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_query(rgs_pkg::req_t r);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    placement_q.push_back(predict_placement(r));
  endtask

  task automatic idle_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (rgs_pkg::OUT_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_spacing(rgs_pkg::snap_t g);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    grid_spacing = g;
  endtask

  function automatic rgs_pkg::req_t make_query(
      rgs_pkg::coord_t rx, rgs_pkg::coord_t ry, rgs_pkg::coord_t rz, rgs_pkg::coord_t ox,
      rgs_pkg::coord_t oy, rgs_pkg::coord_t oz, rgs_pkg::quat_t w, rgs_pkg::quat_t x,
      rgs_pkg::quat_t y, rgs_pkg::quat_t z);
    rgs_pkg::req_t r;
    r = '{rx, ry, rz, ox, oy, oz, w, x, y, z};
    return r;
  endfunction

  function automatic rgs_pkg::coord_t rand_coord();
    case ($urandom_range(3))
      0:       return rgs_pkg::coord_t'($urandom);
      1:       return rgs_pkg::coord_t'($urandom_range(32'h0010_0000) - 32'h0008_0000);
      2:       return $urandom_range(1) ? rgs_pkg::coord_t'(CMAX - $urandom_range(255))
                                        : rgs_pkg::coord_t'(CMIN + $urandom_range(255));
      default: return rgs_pkg::coord_t'($urandom_range(32'h0400_0000) - 32'h0200_0000);
    endcase
  endfunction

  function automatic rgs_pkg::quat_t rand_quat_part();
    case ($urandom_range(5))
      0:       return rgs_pkg::quat_t'($urandom);
      1, 2:    return rgs_pkg::quat_t'(int'($urandom_range(32768)) - 16384);
      3:       return rgs_pkg::quat_t'(int'($urandom_range(2)) * 16384 - 16384);
      default: return rgs_pkg::quat_t'(int'($urandom_range(23170)) - 11585);
    endcase
  endfunction

  function automatic rgs_pkg::req_t rand_query();
    return make_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
                      rand_quat_part());
  endfunction

  task automatic run_random(int count, int idle_pct);
    for (int i = 0; i < count; i++) begin
      idle_gap(idle_pct);
      send_query(rand_query());
    end
    end_burst();
  endtask

  task automatic test_reset_spacing();
    send_query(make_query(32'sd1000, -32'sd777, 32'sd12345, 32'sd5, 32'sd6, 32'sd7,
                          16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    send_query(make_query(32'sd300, 32'sd301, 32'sd302, 32'sd0, 32'sd0, 32'sd0,
                          16'sd11585, 16'sd0, 16'sd0, 16'sd11585));
    end_burst();
  endtask

  task automatic test_directed();
    write_spacing(rgs_pkg::snap_t'(256));
    // Halfway values round up: +0.5 goes to one cell, -0.5 goes to zero.
    send_query(make_query(32'sd0, 32'sd128, -32'sd128, 32'sd0, 32'sd0, 32'sd0,
                          16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    send_query(make_query(32'sd0, -32'sd384, 32'sd640, 32'sd0, 32'sd0, 32'sd0,
                          16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    // Zero quaternion acts as the identity matrix.
    send_query(make_query(32'sd1000, 32'sd2000, 32'sd3000, -32'sd10, 32'sd20, 32'sd30,
                          16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // Extreme coordinates: the difference and the sums saturate.
    send_query(make_query(rgs_pkg::coord_t'(CMAX), rgs_pkg::coord_t'(CMIN),
                          rgs_pkg::coord_t'(CMAX), rgs_pkg::coord_t'(CMIN),
                          rgs_pkg::coord_t'(CMAX), rgs_pkg::coord_t'(CMIN),
                          16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    send_query(make_query(rgs_pkg::coord_t'(CMIN), rgs_pkg::coord_t'(CMAX),
                          rgs_pkg::coord_t'(CMIN), rgs_pkg::coord_t'(CMAX),
                          rgs_pkg::coord_t'(CMIN), rgs_pkg::coord_t'(CMAX),
                          -16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    // Half turns about each axis and quaternion extremes.
    send_query(make_query(32'sd5000, 32'sd6000, 32'sd7000, 32'sd1, 32'sd2, 32'sd3,
                          16'sd0, 16'sd16384, 16'sd0, 16'sd0));
    send_query(make_query(32'sd5000, 32'sd6000, 32'sd7000, 32'sd1, 32'sd2, 32'sd3,
                          16'sd0, 16'sd0, -16'sd16384, 16'sd0));
    send_query(make_query(32'sd5000, 32'sd6000, 32'sd7000, 32'sd1, 32'sd2, 32'sd3,
                          16'sd0, 16'sd0, 16'sd0, 16'sd16384));
    // Non-unit and out-of-range bit patterns clamp the matrix entries.
    send_query(make_query(32'sd99999, -32'sd88888, 32'sd77777, 32'sd0, 32'sd0, 32'sd0,
                          16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384));
    send_query(make_query(32'sd99999, -32'sd88888, 32'sd77777, 32'sd0, 32'sd0, 32'sd0,
                          rgs_pkg::quat_t'(16'h8000), rgs_pkg::quat_t'(16'h7fff),
                          rgs_pkg::quat_t'(16'h8000), rgs_pkg::quat_t'(16'h7fff)));
    send_query(make_query(32'sd99999, -32'sd88888, 32'sd77777, 32'sd0, 32'sd0, 32'sd0,
                          rgs_pkg::quat_t'(16'hffff), rgs_pkg::quat_t'(16'h5555),
                          rgs_pkg::quat_t'(16'haaaa), rgs_pkg::quat_t'(16'h0001)));
    end_burst();
    // Largest grid: the snapped value still fits within the coordinate range.
    write_spacing(rgs_pkg::snap_t'(24'hffffff));
    send_query(make_query(rgs_pkg::coord_t'(CMAX), rgs_pkg::coord_t'(CMAX),
                          rgs_pkg::coord_t'(CMIN), 32'sd0, 32'sd0, 32'sd0,
                          16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    send_query(make_query(rgs_pkg::coord_t'(CMIN), 32'sd8388607, -32'sd8388608,
                          32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0));
    send_query(make_query(32'sd0, 32'sd2147483000, 32'sd1, 32'sd0, 32'sd0, 32'sd0,
                          16'sd11585, 16'sd11585, 16'sd0, 16'sd0));
    end_burst();
  endtask

  task automatic test_spacing_sweep();
    write_spacing(rgs_pkg::snap_t'(1));
    run_random(100, 0);
    write_spacing(rgs_pkg::snap_t'(24'hffffff));
    run_random(100, 0);
    write_spacing(rgs_pkg::snap_t'($urandom_range(24'hffffff)));
    run_random(100, 0);
    write_spacing(rgs_pkg::snap_t'($urandom_range(4096, 1)));
    run_random(100, 0);
  endtask

  task automatic test_sender_idle();
    write_spacing(rgs_pkg::snap_t'(24'h000100));
    run_random(300, 81);
  endtask

  task automatic test_mixed_idle();
    write_spacing(rgs_pkg::snap_t'(24'h000000));
    run_random(150, 9);
    write_spacing(rgs_pkg::snap_t'($urandom));
    run_random(150, 9);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    grid_spacing = '0;
    mismatches   = 0;
    stall_cycles = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_spacing();
    test_directed();
    test_spacing_sweep();
    test_sender_idle();
    test_mixed_idle();

    drain_results();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rgs_pkg.sv
rtl/rgs_rot_mat.sv
rtl/rgs_mat_vec.sv
rtl/rgs_snap.sv
rtl/rotated_grid_snap.sv
sim/tb_rotated_grid_snap.sv
